>>> hw/rtl/line_clip_outcode_assert.svh
// assertion macros used by the clipper back end
// no dependencies
`ifndef LINE_CLIP_OUTCODE_ASSERT_SVH
`define LINE_CLIP_OUTCODE_ASSERT_SVH
// plain implication check under reset
`define LCO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check under reset
`define LCO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/lco_pkg.sv
// shared types and constants for the line clipper
// no dependencies
`default_nettype none
package lco_pkg;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned MaxMoves     = 8;

  localparam logic [3:0] OcLeft   = 4'd1;
  localparam logic [3:0] OcRight  = 4'd2;
  localparam logic [3:0] OcBottom = 4'd4;
  localparam logic [3:0] OcTop    = 4'd8;

  localparam logic [1:0] RegXMin = 2'd0;
  localparam logic [1:0] RegYMin = 2'd1;
  localparam logic [1:0] RegXMax = 2'd2;
  localparam logic [1:0] RegYMax = 2'd3;

  typedef struct packed {
    logic signed [CoordBitsDef-1:0] start_x;
    logic signed [CoordBitsDef-1:0] start_y;
    logic signed [CoordBitsDef-1:0] end_x;
    logic signed [CoordBitsDef-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic                           accepted;
    logic signed [CoordBitsDef-1:0] clipped_start_x;
    logic signed [CoordBitsDef-1:0] clipped_start_y;
    logic signed [CoordBitsDef-1:0] clipped_end_x;
    logic signed [CoordBitsDef-1:0] clipped_end_y;
  } seg_out_t;
endpackage
`default_nettype wire

>>> hw/rtl/lco_front.sv
// front end: takes segment beats and queues them for the clip engine
// depends on lco_pkg
`default_nettype none
module lco_front
  import lco_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire seg_in_t in_data_i,
  output logic         q_valid_o,
  input  wire logic    q_pop_i,
  output seg_in_t      q_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  seg_in_t          mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_stall_o = (cnt_q == AW'(0) + (AW+1)'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != '0);
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/lco_muldiv.sv
// serial signed (a*b)/d, quotient truncated toward zero, zero if d is 0
// depends on lco_pkg
`default_nettype none
module lco_muldiv
  import lco_pkg::*;
#(
  parameter int unsigned W = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  input  wire logic signed [W-1:0] d_i,
  output logic                     done_o,
  output logic signed [W-1:0]      q_o
);
  localparam int unsigned PW = 2*W;
  localparam int unsigned CW = $clog2(PW+2);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_e;
  st_e          st_q;
  logic [PW-1:0] prod_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  ud_q, ub_q;
  logic [PW-1:0] q_q;
  logic          neg_q, dz_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    rem_sh;
  logic [W-1:0]  ua, ub, ud;

  assign ua = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign ub = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign ud = d_i[W-1] ? W'(-d_i) : W'(d_i);
  assign rem_sh = {rem_q[W-1:0], prod_q[PW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; done_o <= 1'b0; cnt_q <= '0;
      prod_q <= '0; rem_q <= '0; ud_q <= '0; ub_q <= '0; q_q <= '0;
      neg_q <= 1'b0; dz_q <= 1'b0; q_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (st_q)
        S_IDLE: if (start_i) begin
          // shift-add multiply: multiplier bits of a consumed lsb first
          prod_q <= {{W{1'b0}}, ua};
          ub_q   <= ub;
          ud_q   <= ud;
          neg_q  <= a_i[W-1] ^ b_i[W-1] ^ d_i[W-1];
          dz_q   <= (d_i == '0);
          cnt_q  <= '0;
          st_q   <= S_MUL;
        end
        S_MUL: begin
          // upper half accumulates, product shifts right
          if (prod_q[0])
            prod_q <= PW'({1'b0, prod_q[PW-1:W]} + {1'b0, ub_q}) << (W-1)
                      | PW'(prod_q[W-1:1]);
          else
            prod_q <= prod_q >> 1;
          if (cnt_q == CW'(W-1)) begin
            cnt_q <= '0; rem_q <= '0; q_q <= '0; st_q <= S_DIV;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_DIV: begin
          prod_q <= prod_q << 1;
          if (rem_sh >= {1'b0, ud_q}) begin
            rem_q <= rem_sh - {1'b0, ud_q};
            q_q   <= {q_q[PW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            q_q   <= {q_q[PW-2:0], 1'b0};
          end
          if (cnt_q == CW'(PW-1)) st_q <= S_FIN;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_FIN: begin
          q_o    <= dz_q ? '0 : (neg_q ? -W'(q_q[W-1:0]) : W'(q_q[W-1:0]));
          done_o <= 1'b1;
          st_q   <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/lco_back.sv
// back end: outcode loop that moves endpoints onto window edges
// depends on lco_pkg, lco_muldiv and the assertion macro header
`default_nettype none
`include "line_clip_outcode_assert.svh"
module lco_back
  import lco_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire seg_in_t                     q_data_i,
  output logic                             q_pop_o,
  input  wire logic signed [CoordBits-1:0] xmin_i,
  input  wire logic signed [CoordBits-1:0] ymin_i,
  input  wire logic signed [CoordBits-1:0] xmax_i,
  input  wire logic signed [CoordBits-1:0] ymax_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output seg_out_t                         out_data_o
);
  localparam int unsigned FW = CoordBits + FracBits;
  localparam int unsigned MW = FW + 2;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_WAIT, S_OUT} st_e;
  st_e st_q;
  logic signed [FW-1:0] x1_q, y1_q, x2_q, y2_q, e_q;
  logic [3:0] c1, c2, co;
  logic [3:0] moves_q;
  logic       vert_q, first_q;
  logic       md_start, md_done;
  logic signed [MW-1:0] md_a, md_b, md_d, md_q, base_ext;
  logic signed [FW-1:0] exmin, eymin, exmax, eymax, e_sel;
  logic       vert;

  function automatic logic signed [FW-1:0] fx(input logic signed [CoordBits-1:0] v);
    fx = {v, {FracBits{1'b0}}};
  endfunction
  function automatic logic signed [CoordBits-1:0] tr(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] t;
    t = v + ((v[FW-1] && FracBits > 0) ? FW'((1 << FracBits) - 1) : FW'(0));
    tr = t[FW-1 -: CoordBits];
  endfunction
  function automatic logic [3:0] oc(input logic signed [FW-1:0] x, y,
                                    input logic signed [FW-1:0] xl, yl, xh, yh);
    oc = '0;
    if (x < xl) oc |= OcLeft;
    if (x > xh) oc |= OcRight;
    if (y < yl) oc |= OcTop;
    if (y > yh) oc |= OcBottom;
  endfunction

  assign exmin = fx(xmin_i);
  assign eymin = fx(ymin_i);
  assign exmax = fx(xmax_i);
  assign eymax = fx(ymax_i);
  assign c1 = oc(x1_q, y1_q, exmin, eymin, exmax, eymax);
  assign c2 = oc(x2_q, y2_q, exmin, eymin, exmax, eymax);
  assign co = (c1 != '0) ? c1 : c2;
  assign vert  = (co & (OcTop | OcBottom)) != '0;
  assign e_sel = vert ? (((co & OcTop) != '0) ? eymin : eymax)
                      : (((co & OcLeft) != '0) ? exmin : exmax);

  assign md_start = (st_q == S_DECIDE) && (c1 != '0 || c2 != '0)
                    && ((c1 & c2) == '0) && (moves_q != 4'(MaxMoves));
  assign md_a = vert ? MW'(x2_q) - MW'(x1_q) : MW'(y2_q) - MW'(y1_q);
  assign md_b = vert ? MW'(e_sel) - MW'(y1_q) : MW'(e_sel) - MW'(x1_q);
  assign md_d = vert ? MW'(y2_q) - MW'(y1_q) : MW'(x2_q) - MW'(x1_q);
  assign base_ext = vert_q ? MW'(x1_q) : MW'(y1_q);
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i;

  lco_muldiv #(.W(MW)) u_md (
    .clk_i, .rst_ni, .start_i(md_start), .a_i(md_a), .b_i(md_b), .d_i(md_d),
    .done_o(md_done), .q_o(md_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; out_valid_o <= 1'b0; moves_q <= '0;
      vert_q <= 1'b0; first_q <= 1'b0; e_q <= '0;
      x1_q <= '0; y1_q <= '0; x2_q <= '0; y2_q <= '0; out_data_o <= '0;
    end else begin
      if (st_q == S_OUT && (!out_valid_o || !out_stall_i)) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (st_q)
        S_IDLE: if (q_valid_i) begin
          x1_q <= fx(CoordBits'(q_data_i.start_x));
          y1_q <= fx(CoordBits'(q_data_i.start_y));
          x2_q <= fx(CoordBits'(q_data_i.end_x));
          y2_q <= fx(CoordBits'(q_data_i.end_y));
          moves_q <= '0;
          st_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (md_start) begin
            vert_q <= vert; first_q <= (c1 != '0); e_q <= e_sel;
            moves_q <= moves_q + 1'b1;
            st_q <= S_WAIT;
          end else st_q <= S_OUT;
        end
        S_WAIT: if (md_done) begin
          // new point: base coordinate plus offset, edge coordinate exact
          if (first_q) begin
            if (vert_q) begin x1_q <= FW'(base_ext + md_q); y1_q <= e_q; end
            else begin y1_q <= FW'(base_ext + md_q); x1_q <= e_q; end
          end else begin
            if (vert_q) begin x2_q <= FW'(base_ext + md_q); y2_q <= e_q; end
            else begin y2_q <= FW'(base_ext + md_q); x2_q <= e_q; end
          end
          st_q <= S_DECIDE;
        end
        S_OUT: if (!out_valid_o || !out_stall_i) begin
          out_data_o.accepted <= (c1 == '0) && (c2 == '0);
          out_data_o.clipped_start_x <= (c1 == '0 && c2 == '0) ?
                                        CoordBitsDef'(tr(x1_q)) : '0;
          out_data_o.clipped_start_y <= (c1 == '0 && c2 == '0) ?
                                        CoordBitsDef'(tr(y1_q)) : '0;
          out_data_o.clipped_end_x   <= (c1 == '0 && c2 == '0) ?
                                        CoordBitsDef'(tr(x2_q)) : '0;
          out_data_o.clipped_end_y   <= (c1 == '0 && c2 == '0) ?
                                        CoordBitsDef'(tr(y2_q)) : '0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `LCO_ASSERT_IMPL(a_moves_bound, clk_i, rst_ni, 1'b1, moves_q <= 4'(MaxMoves), "too many moves")
  `LCO_ASSERT_NEXT(a_start_wait, clk_i, rst_ni, md_start, st_q == S_WAIT, "divider start lost")
  `LCO_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == S_IDLE, "pop while busy")
endmodule
`default_nettype wire

>>> hw/rtl/line_clip_outcode.sv
// cohen-sutherland line clipper, q16.8 fixed point edge moves
// the engine clips one segment at a time; a serial multiply-divide computes each edge move
// a two-beat input queue decouples the front
// reset: window regs go to 200,200,400,350; queue and engine empty
`default_nettype none
module line_clip_outcode
  import lco_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire seg_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output seg_out_t      out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [COORD_BITS-1:0] cfg_data_i
);
  // window edge registers
  logic signed [COORD_BITS-1:0] xmin_q, ymin_q, xmax_q, ymax_q;
  logic    q_valid, q_pop;
  seg_in_t q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= COORD_BITS'(200); ymin_q <= COORD_BITS'(200);
      xmax_q <= COORD_BITS'(400); ymax_q <= COORD_BITS'(350);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegXMin: xmin_q <= COORD_BITS'(signed'(cfg_data_i));
        RegYMin: ymin_q <= COORD_BITS'(signed'(cfg_data_i));
        RegXMax: xmax_q <= COORD_BITS'(signed'(cfg_data_i));
        RegYMax: ymax_q <= COORD_BITS'(signed'(cfg_data_i));
        default: ;
      endcase
    end
  end

  // front: accepts beats into a short queue
  lco_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  // back: iterative clip engine with output register
  lco_back #(.CoordBits(COORD_BITS), .FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .xmin_i(xmin_q), .ymin_i(ymin_q), .xmax_i(xmax_q), .ymax_i(ymax_q),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire

>>> tb/line_clip_outcode_tb.sv
// testbench for the cohen-sutherland line clipper line_clip_outcode
// checks every output beat against a fixed-point clipping predictor or a directed expectation
// depends on lco_pkg and the line_clip_outcode rtl
`timescale 1ns / 1ps
`default_nettype none
module line_clip_outcode_tb;
  import lco_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int ItemsPerPhase = 225;
  localparam int NumPhases     = 8;
  localparam longint FixOne    = 256;

  // idling modes, cycled through by phase
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  seg_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  seg_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegXMin;
  logic [15:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  line_clip_outcode uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor copy of the window registers, in integer units
  longint win_xmin = 200, win_ymin = 200, win_xmax = 400, win_ymax = 350;

  seg_out_t   clipped_q[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  idle_mode_e idle_mode = IdleNone;

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_xmin * FixOne) c |= OcLeft;
    if (x > win_xmax * FixOne) c |= OcRight;
    if (y < win_ymin * FixOne) c |= OcTop;
    if (y > win_ymax * FixOne) c |= OcBottom;
    return c;
  endfunction

  // exact wide product, quotient truncated toward zero, low 64 bits kept
  function automatic longint scaled_offset(longint a, longint b, longint d);
    logic signed [127:0] wa, wb, wd, q;
    if (d == 0) return 0;
    wa = a;
    wb = b;
    wd = d;
    q = (wa * wb) / wd;
    return q[63:0];
  endfunction

  function automatic seg_out_t clip_segment(seg_in_t s);
    longint x1, y1, x2, y2, x, y, e;
    logic [3:0] c1, c2, co;
    logic ok;
    seg_out_t r;
    x1 = longint'(s.start_x) * FixOne;
    y1 = longint'(s.start_y) * FixOne;
    x2 = longint'(s.end_x) * FixOne;
    y2 = longint'(s.end_y) * FixOne;
    c1 = region_code(x1, y1);
    c2 = region_code(x2, y2);
    ok = 1'b0;
    for (int m = 0; m <= MaxMoves; m++) begin
      if (c1 == 0 && c2 == 0) begin
        ok = 1'b1;
        break;
      end
      if ((c1 & c2) != 0 || m == MaxMoves) break;
      co = (c1 != 0) ? c1 : c2;
      if ((co & (OcTop | OcBottom)) != 0) begin
        e = (((co & OcTop) != 0) ? win_ymin : win_ymax) * FixOne;
        x = x1 + scaled_offset(x2 - x1, e - y1, y2 - y1);
        y = e;
      end else begin
        e = (((co & OcLeft) != 0) ? win_xmin : win_xmax) * FixOne;
        y = y1 + scaled_offset(y2 - y1, e - x1, x2 - x1);
        x = e;
      end
      if (co == c1) begin
        x1 = x; y1 = y; c1 = region_code(x1, y1);
      end else begin
        x2 = x; y2 = y; c2 = region_code(x2, y2);
      end
    end
    r = '0;
    r.accepted = ok;
    if (ok) begin
      r.clipped_start_x = 16'(x1 / FixOne);
      r.clipped_start_y = 16'(y1 / FixOne);
      r.clipped_end_x   = 16'(x2 / FixOne);
      r.clipped_end_y   = 16'(y2 / FixOne);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, seg_out_t got, seg_out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // output monitor: compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    seg_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clipped_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o, '0);
      end else begin
        want = clipped_q.pop_front();
        if (out_data_o.accepted !== want.accepted)
          report_mismatch("accepted", out_data_o, want);
        else if (out_data_o.clipped_start_x !== want.clipped_start_x)
          report_mismatch("clipped_start_x", out_data_o, want);
        else if (out_data_o.clipped_start_y !== want.clipped_start_y)
          report_mismatch("clipped_start_y", out_data_o, want);
        else if (out_data_o.clipped_end_x !== want.clipped_end_x)
          report_mismatch("clipped_end_x", out_data_o, want);
        else if (out_data_o.clipped_end_y !== want.clipped_end_y)
          report_mismatch("clipped_end_y", out_data_o, want);
      end
    end
  end

  // receiver back-pressure follows the idle mode
  always @(posedge clk_i) begin
    if (idle_mode == IdleReceiver) out_stall_i <= ($urandom_range(99) < 85);
    else if (idle_mode == IdleBoth) out_stall_i <= ($urandom_range(99) < 20);
    else out_stall_i <= 1'b0;
  end

  // watchdog on cycles where no channel moves a beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one config beat; valid stays high into the next write, caller drops it
  task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegXMin: win_xmin = val;
      RegYMin: win_ymin = val;
      RegXMax: win_xmax = val;
      RegYMax: win_ymax = val;
      default: ;
    endcase
  endtask

  // one input beat; valid stays high into the next beat unless we idle
  task automatic send_segment(seg_in_t s, logic typed, seg_out_t want);
    int gap_pct;
    gap_pct = (idle_mode == IdleSender) ? 85 : (idle_mode == IdleBoth) ? 20 : 0;
    if (gap_pct > 0) begin
      while ($urandom_range(99) < gap_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    clipped_q.push_back(typed ? want : clip_segment(s));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // random coordinate: mostly near a window edge pair, sometimes anything
  function automatic logic signed [15:0] pick_coord(longint lo, longint hi);
    int sel;
    longint span;
    sel = $urandom_range(9);
    span = (hi > lo ? hi - lo : lo - hi) + 64;
    if (sel < 2) return 16'($urandom);
    if (sel < 4) return 16'(lo + $signed($urandom_range(16)) - 8);
    if (sel < 6) return 16'(hi + $signed($urandom_range(16)) - 8);
    return 16'(((lo < hi) ? lo : hi) - span / 2 + $urandom_range(2 * span));
  endfunction

  typedef struct {
    seg_in_t  seg;
    logic     typed;
    seg_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // fully inside the reset window
    '{'{16'sd250, 16'sd250, 16'sd300, 16'sd300}, 1'b1,
      '{1'b1, 16'sd250, 16'sd250, 16'sd300, 16'sd300}},
    // both endpoints left: trivial reject
    '{'{16'sd0, 16'sd0, 16'sd100, 16'sd300}, 1'b1, '0},
    // both endpoints above the top edge: trivial reject
    '{'{16'sd250, -16'sd5, 16'sd390, 16'sd199}, 1'b1, '0},
    // both right, both below
    '{'{16'sd401, 16'sd250, 16'sd32767, 16'sd300}, 1'b1, '0},
    '{'{16'sd250, 16'sd351, 16'sd300, 16'sd32767}, 1'b1, '0},
    // window corners exactly
    '{'{16'sd200, 16'sd200, 16'sd400, 16'sd350}, 1'b1,
      '{1'b1, 16'sd200, 16'sd200, 16'sd400, 16'sd350}},
    // degenerate point inside and outside
    '{'{16'sd300, 16'sd300, 16'sd300, 16'sd300}, 1'b1,
      '{1'b1, 16'sd300, 16'sd300, 16'sd300, 16'sd300}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, '0},
    // extreme diagonals
    '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, '0},
    // crossings of one or two window sides, vertical and horizontal
    '{'{16'sd100, 16'sd275, 16'sd500, 16'sd275}, 1'b0, '0},
    '{'{16'sd300, 16'sd0, 16'sd300, 16'sd500}, 1'b0, '0},
    '{'{16'sd300, 16'sd300, 16'sd900, 16'sd333}, 1'b0, '0},
    '{'{16'sd0, 16'sd301, 16'sd301, 16'sd0}, 1'b0, '0},
    // outside both codes without sharing a bit: one missing the window, one crossing it
    '{'{16'sd0, 16'sd340, 16'sd210, 16'sd1000}, 1'b0, '0},
    '{'{16'sd150, 16'sd100, 16'sd450, 16'sd400}, 1'b0, '0},
    // corner grazing
    '{'{16'sd100, 16'sd300, 16'sd300, 16'sd100}, 1'b0, '0},
    '{'{16'sd401, 16'sd0, 16'sd0, 16'sd351}, 1'b0, '0}
  };

  initial begin
    seg_in_t s;
    longint lo_x, hi_x, lo_y, hi_y;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows against the reset window
    foreach (dir_rows[i]) send_segment(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].want);
    wait_drain();

    for (int p = 1; p <= NumPhases; p++) begin
      idle_mode = idle_mode_e'(p % 4);
      case (p)
        2: begin lo_x = -32768; lo_y = -32768; hi_x = 32767; hi_y = 32767; end
        4: begin lo_x = 500; lo_y = 400; hi_x = -100; hi_y = 50; end  // inverted
        6: begin lo_x = 77; lo_y = -12; hi_x = 77; hi_y = -12; end    // single point
        8: begin lo_x = 32767; lo_y = 32767; hi_x = -32768; hi_y = -32768; end
        default: begin
          lo_x = $signed($urandom_range(4000)) - 2000;
          lo_y = $signed($urandom_range(4000)) - 2000;
          hi_x = lo_x + $urandom_range(3000);
          hi_y = lo_y + $urandom_range(3000);
        end
      endcase
      write_reg(RegXMin, 16'(lo_x));
      write_reg(RegYMin, 16'(lo_y));
      write_reg(RegXMax, 16'(hi_x));
      write_reg(RegYMax, 16'(hi_y));
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        s.start_x = pick_coord(lo_x, hi_x);
        s.start_y = pick_coord(lo_y, hi_y);
        s.end_x   = pick_coord(lo_x, hi_x);
        s.end_y   = pick_coord(lo_y, hi_y);
        send_segment(s, 1'b0, '0);
      end
      wait_drain();
    end

    idle_mode = IdleNone;
    repeat (800) @(posedge clk_i);
    if (mismatches == 0 && clipped_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
